FILE: rtl/mfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared types, constants and helpers for the modified false position root
// finder: payload structs, controller commands and status, state encodings.
// ----------------------------------------------------------------------------
package mfp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_DEGREE = 4;
    localparam int XW         = 32;
    localparam int FW         = 48;
    localparam int CW         = 16;
    localparam int TOLW       = 31;
    localparam int CAPW       = 8;
    localparam int DEGW       = 3;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    localparam logic signed [FW-1:0] F_MAX = {1'b0, {(FW-1){1'b1}}};
    localparam logic signed [FW-1:0] F_MIN = {1'b1, {(FW-1){1'b0}}};

    localparam logic [1:0] OUT_CONVERGED = 2'd0;
    localparam logic [1:0] OUT_NO_SIGN   = 2'd1;
    localparam logic [1:0] OUT_STALLED   = 2'd2;
    localparam logic [1:0] OUT_CAP       = 2'd3;

    localparam logic [2:0] REG_DEGREE    = 3'd0;
    localparam logic [2:0] REG_TOLERANCE = 3'd1;
    localparam logic [2:0] REG_CAP       = 3'd2;
    localparam logic [2:0] REG_COEFF_0   = 3'd3;
    localparam logic [2:0] REG_COEFF_1   = 3'd4;
    localparam logic [2:0] REG_COEFF_2   = 3'd5;
    localparam logic [2:0] REG_COEFF_3   = 3'd6;
    localparam logic [2:0] REG_COEFF_4   = 3'd7;

    typedef struct packed {
        logic signed [XW-1:0] left_end;
        logic signed [XW-1:0] right_end;
    } in_item_t;

    typedef struct packed {
        logic signed [XW-1:0] root_value;
        logic [CAPW-1:0]      iterations_used;
        logic [1:0]           outcome;
    } out_item_t;

    typedef logic [MAX_DEGREE:0][CW-1:0] coeff_arr_t;

    typedef enum logic [1:0] {XS_LO, XS_HI, XS_CUR, XS_PREV} x_sel_t;

    typedef enum logic [1:0] {SM_INIT, SM_LOWER, SM_UPPER} sec_mode_t;

    typedef struct packed {
        logic      load;
        logic      ev_start;
        x_sel_t    ev_sel;
        logic      sec_start;
        sec_mode_t sec_mode;
        logic      take_sec;
        logic      inc_k;
        logic      set_outcome;
        logic [1:0] outcome;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic ev_done;
        logic sec_done;
        logic no_sign;
        logic cap_hit;
        logic res_ok;
        logic rel_ok;
        logic lower_side;
        logic upper_side;
    } sts_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EV_LO, ST_WT_LO, ST_EV_HI, ST_WT_HI, ST_CHECK, ST_WT_SEC0,
        ST_LOOP, ST_EV_CUR, ST_WT_CUR, ST_EV_PREV, ST_WT_PREV, ST_REL,
        ST_DECIDE, ST_WT_SEC, ST_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {HS_IDLE, HS_CHECK, HS_MUL, HS_ADD} horner_state_t;

    typedef enum logic [2:0] {SS_IDLE, SS_NORM, SS_MUL, SS_DIV, SS_FIN} sec_state_t;

    function automatic logic signed [FW-1:0] coeff_scale(input logic [CW-1:0] c);
        logic signed [FW-1:0] t;
        t = {{(FW-CW){c[CW-1]}}, c};
        return t <<< FRAC_BITS;
    endfunction

    function automatic logic [FW-1:0] mag_f(input logic signed [FW-1:0] v);
        logic [FW-1:0] r;
        r = v[FW-1] ? -v : v;
        return r;
    endfunction

    function automatic logic [XW-1:0] mag_x(input logic signed [XW-1:0] v);
        logic [XW-1:0] r;
        r = v[XW-1] ? -v : v;
        return r;
    endfunction

endpackage

FILE: rtl/mfp_horner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfp_horner
// Horner evaluation of the configured polynomial at one Q16.16 point. Each
// step multiplies in 16-bit slices, then adds the next coefficient with
// saturation to 48 bits.
// ----------------------------------------------------------------------------
module mfp_horner (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [mfp_pkg::XW-1:0] x,
    input  logic [mfp_pkg::DEGW-1:0]      degree,
    input  mfp_pkg::coeff_arr_t           coeffs,
    output logic                          done,
    output logic signed [mfp_pkg::FW-1:0] result
);

    localparam int PW     = mfp_pkg::FW + mfp_pkg::XW;
    localparam int SW     = mfp_pkg::FW + 3;
    localparam int SLICES = mfp_pkg::FW / 16;
    localparam logic [63:0] Q_CAP = 64'(1) << mfp_pkg::FW;

    mfp_pkg::horner_state_t state_reg, state_next;
    logic signed [mfp_pkg::FW-1:0] acc_reg, acc_next;
    logic [mfp_pkg::DEGW-1:0]      idx_reg, idx_next;
    logic [1:0]                    part_reg, part_next;
    logic [PW-1:0]                 prod_reg, prod_next;
    logic [mfp_pkg::FW-1:0]        ma_reg, ma_next;
    logic [mfp_pkg::XW-1:0]        mb_reg, mb_next;
    logic                          neg_reg, neg_next;
    logic signed [mfp_pkg::XW-1:0] x_reg, x_next;

    logic [mfp_pkg::DEGW-1:0]      deg_use;
    logic [mfp_pkg::DEGW-1:0]      idx_dec;
    logic [15:0]                   piece;
    logic [mfp_pkg::XW+15:0]       pp;
    logic [63:0]                   q_raw;
    logic [mfp_pkg::FW:0]          q_cap;
    logic signed [SW-1:0]          term;
    logic signed [SW-1:0]          csum;

    always_comb begin
        deg_use = (degree > mfp_pkg::DEGW'(mfp_pkg::MAX_DEGREE)) ?
                  mfp_pkg::DEGW'(mfp_pkg::MAX_DEGREE) : degree;
        idx_dec = idx_reg - mfp_pkg::DEGW'(1);
        piece   = ma_reg[{part_reg, 4'b0000} +: 16];
        pp      = piece * mb_reg;
        q_raw   = 64'(prod_reg >> mfp_pkg::FRAC_BITS);
        q_cap   = (q_raw > Q_CAP) ? Q_CAP[mfp_pkg::FW:0] : q_raw[mfp_pkg::FW:0];
        term    = SW'(signed'({1'b0, q_cap}));
        if (neg_reg) begin
            term = -term;
        end
        csum = term + SW'(mfp_pkg::coeff_scale(coeffs[idx_dec]));
    end

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        idx_next   = idx_reg;
        part_next  = part_reg;
        prod_next  = prod_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        neg_next   = neg_reg;
        x_next     = x_reg;
        case (state_reg)
            mfp_pkg::HS_IDLE: begin
                if (start) begin
                    x_next     = x;
                    acc_next   = mfp_pkg::coeff_scale(coeffs[deg_use]);
                    idx_next   = deg_use;
                    state_next = mfp_pkg::HS_CHECK;
                end
            end
            mfp_pkg::HS_CHECK: begin
                if (idx_reg == '0) begin
                    state_next = mfp_pkg::HS_IDLE;
                end else begin
                    ma_next    = mfp_pkg::mag_f(acc_reg);
                    mb_next    = mfp_pkg::mag_x(x_reg);
                    neg_next   = acc_reg[mfp_pkg::FW-1] ^ x_reg[mfp_pkg::XW-1];
                    prod_next  = '0;
                    part_next  = '0;
                    state_next = mfp_pkg::HS_MUL;
                end
            end
            mfp_pkg::HS_MUL: begin
                prod_next = prod_reg + (PW'(pp) << {part_reg, 4'b0000});
                if (part_reg == 2'(SLICES - 1)) begin
                    state_next = mfp_pkg::HS_ADD;
                end else begin
                    part_next = part_reg + 2'd1;
                end
            end
            mfp_pkg::HS_ADD: begin
                if (csum > SW'(mfp_pkg::F_MAX)) begin
                    acc_next = mfp_pkg::F_MAX;
                end else if (csum < SW'(mfp_pkg::F_MIN)) begin
                    acc_next = mfp_pkg::F_MIN;
                end else begin
                    acc_next = csum[mfp_pkg::FW-1:0];
                end
                idx_next   = idx_dec;
                state_next = mfp_pkg::HS_CHECK;
            end
            default: begin
                state_next = mfp_pkg::HS_IDLE;
            end
        endcase
    end

    assign done   = (state_reg == mfp_pkg::HS_CHECK) && (idx_reg == '0);
    assign result = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mfp_pkg::HS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        acc_reg  <= acc_next;
        idx_reg  <= idx_next;
        part_reg <= part_next;
        prod_reg <= prod_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        neg_reg  <= neg_next;
        x_reg    <= x_next;
    end

endmodule

FILE: rtl/mfp_secant.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfp_secant
// Secant point a + sgn(b-a) * floor(|b-a| * n / s): normalize s below 2^31,
// one multiply, then a restoring divide one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mfp_secant (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [mfp_pkg::XW-1:0] a,
    input  logic signed [mfp_pkg::XW-1:0] b,
    input  logic [mfp_pkg::FW-1:0]        na,
    input  logic [mfp_pkg::FW-1:0]        nb,
    output logic                          done,
    output logic signed [mfp_pkg::XW-1:0] q_x
);

    localparam int SNW  = mfp_pkg::FW + 1;
    localparam int DW   = 31;
    localparam int NUMW = mfp_pkg::XW + DW;

    mfp_pkg::sec_state_t state_reg, state_next;
    logic signed [mfp_pkg::XW-1:0] a_reg, a_next;
    logic                          wneg_reg, wneg_next;
    logic [mfp_pkg::XW-1:0]        wmag_reg, wmag_next;
    logic [SNW-1:0]                n_reg, n_next;
    logic [SNW-1:0]                s_reg, s_next;
    logic [NUMW-1:0]               num_reg, num_next;
    logic [DW-1:0]                 rem_reg, rem_next;
    logic [mfp_pkg::XW-1:0]        quo_reg, quo_next;
    logic [5:0]                    cnt_reg, cnt_next;

    logic signed [mfp_pkg::XW:0]   diff;
    logic [DW:0]                   rem_sh;
    logic                          fits;

    always_comb begin
        diff   = (mfp_pkg::XW+1)'(b) - (mfp_pkg::XW+1)'(a);
        rem_sh = {rem_reg, num_reg[NUMW-1]};
        fits   = rem_sh >= (DW+1)'(s_reg[DW-1:0]);
    end

    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        wneg_next  = wneg_reg;
        wmag_next  = wmag_reg;
        n_next     = n_reg;
        s_next     = s_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            mfp_pkg::SS_IDLE: begin
                if (start) begin
                    a_next     = a;
                    wneg_next  = diff[mfp_pkg::XW];
                    wmag_next  = diff[mfp_pkg::XW] ? mfp_pkg::XW'(-diff)
                                                   : diff[mfp_pkg::XW-1:0];
                    n_next     = SNW'(na);
                    s_next     = SNW'(na) + SNW'(nb);
                    state_next = mfp_pkg::SS_NORM;
                end
            end
            mfp_pkg::SS_NORM: begin
                if (s_reg == '0) begin
                    quo_next   = '0;
                    state_next = mfp_pkg::SS_FIN;
                end else if (|s_reg[SNW-1:DW]) begin
                    n_next = n_reg >> 1;
                    s_next = s_reg >> 1;
                end else begin
                    state_next = mfp_pkg::SS_MUL;
                end
            end
            mfp_pkg::SS_MUL: begin
                num_next   = wmag_reg * n_reg[DW-1:0];
                rem_next   = '0;
                quo_next   = '0;
                cnt_next   = 6'(NUMW - 1);
                state_next = mfp_pkg::SS_DIV;
            end
            mfp_pkg::SS_DIV: begin
                rem_next = fits ? DW'(rem_sh - (DW+1)'(s_reg[DW-1:0])) : rem_sh[DW-1:0];
                quo_next = {quo_reg[mfp_pkg::XW-2:0], fits};
                num_next = num_reg << 1;
                if (cnt_reg == '0) begin
                    state_next = mfp_pkg::SS_FIN;
                end else begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            mfp_pkg::SS_FIN: begin
                state_next = mfp_pkg::SS_IDLE;
            end
            default: begin
                state_next = mfp_pkg::SS_IDLE;
            end
        endcase
    end

    assign done = (state_reg == mfp_pkg::SS_FIN);
    assign q_x  = wneg_reg ? a_reg - signed'(quo_reg) : a_reg + signed'(quo_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mfp_pkg::SS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        a_reg    <= a_next;
        wneg_reg <= wneg_next;
        wmag_reg <= wmag_next;
        n_reg    <= n_next;
        s_reg    <= s_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
    end

endmodule

FILE: rtl/mfp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfp_datapath
// Bracket, estimate and polynomial value registers, the shared Horner and
// secant units, the stop tests and the result register.
// ----------------------------------------------------------------------------
module mfp_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mfp_pkg::cmd_t               cmd,
    output mfp_pkg::sts_t               sts,
    input  mfp_pkg::in_item_t           in_item,
    output mfp_pkg::out_item_t          out_item,
    input  logic [mfp_pkg::DEGW-1:0]    degree,
    input  logic [mfp_pkg::TOLW-1:0]    tolerance,
    input  logic [mfp_pkg::CAPW-1:0]    cap,
    input  mfp_pkg::coeff_arr_t         coeffs
);

    localparam int RW = mfp_pkg::TOLW + mfp_pkg::XW - mfp_pkg::FRAC_BITS;
    localparam int DFW = mfp_pkg::FW + 1;
    localparam int TPW = mfp_pkg::TOLW + mfp_pkg::XW;

    logic signed [mfp_pkg::XW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic signed [mfp_pkg::XW-1:0] prev_reg, prev_next, cur_reg, cur_next;
    logic signed [mfp_pkg::FW-1:0] fl_reg, fl_next, fu_reg, fu_next;
    logic signed [mfp_pkg::FW-1:0] fc_reg, fc_next, fp_reg, fp_next;
    logic [mfp_pkg::CAPW-1:0]      k_reg, k_next;
    logic [1:0]                    outcome_reg, outcome_next;
    mfp_pkg::x_sel_t               sel_reg, sel_next;
    logic [RW-1:0]                 thr_reg;
    logic [DFW-1:0]                dmag_reg;
    mfp_pkg::out_item_t            out_reg, out_next;

    logic signed [mfp_pkg::XW-1:0] h_x;
    logic                          h_done;
    logic signed [mfp_pkg::FW-1:0] h_result;
    logic signed [mfp_pkg::XW-1:0] s_a, s_b, s_q;
    logic [mfp_pkg::FW-1:0]        s_na, s_nb;
    logic                          s_done;
    logic                          same;
    logic signed [DFW-1:0]         diff;

    mfp_horner u_horner (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.ev_start),
        .x       (h_x),
        .degree  (degree),
        .coeffs  (coeffs),
        .done    (h_done),
        .result  (h_result)
    );

    mfp_secant u_secant (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.sec_start),
        .a       (s_a),
        .b       (s_b),
        .na      (s_na),
        .nb      (s_nb),
        .done    (s_done),
        .q_x     (s_q)
    );

    always_comb begin
        case (cmd.ev_sel)
            mfp_pkg::XS_LO:   h_x = lo_reg;
            mfp_pkg::XS_HI:   h_x = hi_reg;
            mfp_pkg::XS_CUR:  h_x = cur_reg;
            mfp_pkg::XS_PREV: h_x = prev_reg;
            default:          h_x = lo_reg;
        endcase
    end

    always_comb begin
        same = (fp_reg != '0) && (fc_reg != '0) &&
               (fp_reg[mfp_pkg::FW-1] == fc_reg[mfp_pkg::FW-1]);
        case (cmd.sec_mode)
            mfp_pkg::SM_LOWER: begin
                s_a  = lo_reg;
                s_b  = cur_reg;
                s_na = same ? mfp_pkg::mag_f(fl_reg) >> 1 : mfp_pkg::mag_f(fl_reg);
                s_nb = mfp_pkg::mag_f(fc_reg);
            end
            mfp_pkg::SM_UPPER: begin
                s_a  = cur_reg;
                s_b  = hi_reg;
                s_na = mfp_pkg::mag_f(fc_reg);
                s_nb = same ? mfp_pkg::mag_f(fu_reg) >> 1 : mfp_pkg::mag_f(fu_reg);
            end
            default: begin
                s_a  = lo_reg;
                s_b  = hi_reg;
                s_na = mfp_pkg::mag_f(fl_reg);
                s_nb = mfp_pkg::mag_f(fu_reg);
            end
        endcase
    end

    always_comb begin
        diff = DFW'(fp_reg) - DFW'(fc_reg);
        sts.ev_done    = h_done;
        sts.sec_done   = s_done;
        sts.no_sign    = (fl_reg != '0) && (fu_reg != '0) &&
                         (fl_reg[mfp_pkg::FW-1] == fu_reg[mfp_pkg::FW-1]);
        sts.cap_hit    = k_reg >= cap;
        sts.res_ok     = mfp_pkg::mag_f(fc_reg) <= mfp_pkg::FW'(tolerance);
        sts.rel_ok     = (prev_reg != '0) && (dmag_reg <= DFW'(thr_reg));
        sts.lower_side = (fl_reg != '0) && (fc_reg != '0) &&
                         (fl_reg[mfp_pkg::FW-1] != fc_reg[mfp_pkg::FW-1]);
        sts.upper_side = (fc_reg != '0) && (fu_reg != '0) &&
                         (fc_reg[mfp_pkg::FW-1] != fu_reg[mfp_pkg::FW-1]);
    end

    always_comb begin
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        prev_next    = prev_reg;
        cur_next     = cur_reg;
        fl_next      = fl_reg;
        fu_next      = fu_reg;
        fc_next      = fc_reg;
        fp_next      = fp_reg;
        k_next       = k_reg;
        outcome_next = outcome_reg;
        sel_next     = sel_reg;
        out_next     = out_reg;
        if (cmd.load) begin
            lo_next   = in_item.left_end;
            hi_next   = in_item.right_end;
            prev_next = '0;
            cur_next  = '0;
            fc_next   = '0;
            k_next    = '0;
        end
        if (cmd.ev_start) begin
            sel_next = cmd.ev_sel;
        end
        if (h_done) begin
            case (sel_reg)
                mfp_pkg::XS_LO:   fl_next = h_result;
                mfp_pkg::XS_HI:   fu_next = h_result;
                mfp_pkg::XS_CUR:  fc_next = h_result;
                mfp_pkg::XS_PREV: fp_next = h_result;
                default:          fl_next = h_result;
            endcase
        end
        if (cmd.sec_start) begin
            case (cmd.sec_mode)
                mfp_pkg::SM_LOWER: begin
                    hi_next   = cur_reg;
                    fu_next   = fc_reg;
                    prev_next = cur_reg;
                end
                mfp_pkg::SM_UPPER: begin
                    lo_next   = cur_reg;
                    fl_next   = fc_reg;
                    prev_next = cur_reg;
                end
                default: begin
                    prev_next = lo_reg;
                end
            endcase
        end
        if (cmd.take_sec) begin
            cur_next = s_q;
        end
        if (cmd.inc_k) begin
            k_next = k_reg + mfp_pkg::CAPW'(1);
        end
        if (cmd.set_outcome) begin
            outcome_next = cmd.outcome;
        end
        if (cmd.out_load) begin
            out_next.root_value      = cur_reg;
            out_next.iterations_used = k_reg;
            out_next.outcome         = outcome_reg;
        end
    end

    assign out_item = out_reg;

    always_ff @(posedge aclk) begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        prev_reg    <= prev_next;
        cur_reg     <= cur_next;
        fl_reg      <= fl_next;
        fu_reg      <= fu_next;
        fc_reg      <= fc_next;
        fp_reg      <= fp_next;
        k_reg       <= k_next;
        outcome_reg <= outcome_next;
        sel_reg     <= sel_next;
        out_reg     <= out_next;
        thr_reg     <= RW'((TPW'(tolerance) * TPW'(mfp_pkg::mag_x(prev_reg)))
                           >> mfp_pkg::FRAC_BITS);
        dmag_reg    <= diff[DFW-1] ? DFW'(-diff) : DFW'(diff);
    end

endmodule

FILE: rtl/mfp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfp_ctrl
// Sequencer for one search: end point evaluation, bracket check, iteration
// loop with stop tests, and hand-off to the result register.
// ----------------------------------------------------------------------------
module mfp_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output mfp_pkg::cmd_t cmd,
    input  mfp_pkg::sts_t sts
);

    mfp_pkg::ctrl_state_t state_reg, state_next;
    logic                 m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mfp_pkg::ST_IDLE:    if (s_valid) state_next = mfp_pkg::ST_EV_LO;
            mfp_pkg::ST_EV_LO:   state_next = mfp_pkg::ST_WT_LO;
            mfp_pkg::ST_WT_LO:   if (sts.ev_done) state_next = mfp_pkg::ST_EV_HI;
            mfp_pkg::ST_EV_HI:   state_next = mfp_pkg::ST_WT_HI;
            mfp_pkg::ST_WT_HI:   if (sts.ev_done) state_next = mfp_pkg::ST_CHECK;
            mfp_pkg::ST_CHECK: begin
                state_next = sts.no_sign ? mfp_pkg::ST_DONE : mfp_pkg::ST_WT_SEC0;
            end
            mfp_pkg::ST_WT_SEC0: if (sts.sec_done) state_next = mfp_pkg::ST_LOOP;
            mfp_pkg::ST_LOOP: begin
                state_next = sts.cap_hit ? mfp_pkg::ST_DONE : mfp_pkg::ST_EV_CUR;
            end
            mfp_pkg::ST_EV_CUR:  state_next = mfp_pkg::ST_WT_CUR;
            mfp_pkg::ST_WT_CUR:  if (sts.ev_done) state_next = mfp_pkg::ST_EV_PREV;
            mfp_pkg::ST_EV_PREV: state_next = mfp_pkg::ST_WT_PREV;
            mfp_pkg::ST_WT_PREV: if (sts.ev_done) state_next = mfp_pkg::ST_REL;
            mfp_pkg::ST_REL:     state_next = mfp_pkg::ST_DECIDE;
            mfp_pkg::ST_DECIDE: begin
                if (sts.res_ok || sts.rel_ok) begin
                    state_next = mfp_pkg::ST_DONE;
                end else if (sts.lower_side || sts.upper_side) begin
                    state_next = mfp_pkg::ST_WT_SEC;
                end else begin
                    state_next = mfp_pkg::ST_DONE;
                end
            end
            mfp_pkg::ST_WT_SEC:  if (sts.sec_done) state_next = mfp_pkg::ST_LOOP;
            mfp_pkg::ST_DONE:    if (!m_valid_reg || m_ready) state_next = mfp_pkg::ST_IDLE;
            default:             state_next = mfp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            mfp_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            mfp_pkg::ST_EV_LO: begin
                cmd.ev_start = 1'b1;
                cmd.ev_sel   = mfp_pkg::XS_LO;
            end
            mfp_pkg::ST_EV_HI: begin
                cmd.ev_start = 1'b1;
                cmd.ev_sel   = mfp_pkg::XS_HI;
            end
            mfp_pkg::ST_CHECK: begin
                if (sts.no_sign) begin
                    cmd.set_outcome = 1'b1;
                    cmd.outcome     = mfp_pkg::OUT_NO_SIGN;
                end else begin
                    cmd.sec_start = 1'b1;
                    cmd.sec_mode  = mfp_pkg::SM_INIT;
                end
            end
            mfp_pkg::ST_WT_SEC0: begin
                cmd.take_sec = sts.sec_done;
            end
            mfp_pkg::ST_LOOP: begin
                cmd.set_outcome = sts.cap_hit;
                cmd.outcome     = mfp_pkg::OUT_CAP;
            end
            mfp_pkg::ST_EV_CUR: begin
                cmd.ev_start = 1'b1;
                cmd.ev_sel   = mfp_pkg::XS_CUR;
            end
            mfp_pkg::ST_EV_PREV: begin
                cmd.ev_start = 1'b1;
                cmd.ev_sel   = mfp_pkg::XS_PREV;
            end
            mfp_pkg::ST_DECIDE: begin
                if (sts.res_ok || sts.rel_ok) begin
                    cmd.set_outcome = 1'b1;
                    cmd.outcome     = mfp_pkg::OUT_CONVERGED;
                end else if (sts.lower_side) begin
                    cmd.sec_start = 1'b1;
                    cmd.sec_mode  = mfp_pkg::SM_LOWER;
                end else if (sts.upper_side) begin
                    cmd.sec_start = 1'b1;
                    cmd.sec_mode  = mfp_pkg::SM_UPPER;
                end else begin
                    cmd.set_outcome = 1'b1;
                    cmd.outcome     = mfp_pkg::OUT_STALLED;
                end
            end
            mfp_pkg::ST_WT_SEC: begin
                cmd.take_sec = sts.sec_done;
                cmd.inc_k    = sts.sec_done;
            end
            mfp_pkg::ST_DONE: begin
                cmd.out_load = !m_valid_reg || m_ready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mfp_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: rtl/modified_false_position_root.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modified_false_position_root
// Illinois-style false position root finder for a configured polynomial of
// degree up to four over a Q16.16 interval, with APB register access.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    in_item_t  {left_end, right_end}
//  m_        out        m_valid/m_ready    out_item_t {root_value, iterations_used, outcome}
//  apb       in/out     psel/penable       paddr[4:2] selects one of eight registers
//
//  One search at a time. A secant uses the bit-serial divider.
//  Each iteration costs two evaluations plus one secant; an item takes two
//  end point evaluations and one secant, plus that per iteration, plus the
//  closing test and one hand-off.
//  Reset is synchronous, active low; no clearing pass is needed.
//  A waiting result does not block the next search from starting.
// ----------------------------------------------------------------------------
module modified_false_position_root (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  mfp_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mfp_pkg::out_item_t            m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mfp_pkg::ADDR_W-1:0]    paddr,
    input  logic [mfp_pkg::DATA_W-1:0]    pwdata,
    output logic [mfp_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic [mfp_pkg::DEGW-1:0] degree_reg, degree_next;
    logic [mfp_pkg::TOLW-1:0] tol_reg, tol_next;
    logic [mfp_pkg::CAPW-1:0] cap_reg, cap_next;
    mfp_pkg::coeff_arr_t      coeff_reg, coeff_next;

    logic          wr_en;
    logic [2:0]    reg_idx;
    mfp_pkg::cmd_t cmd;
    mfp_pkg::sts_t sts;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[mfp_pkg::ADDR_W-1:2];

    always_comb begin
        degree_next = degree_reg;
        tol_next    = tol_reg;
        cap_next    = cap_reg;
        coeff_next  = coeff_reg;
        if (wr_en) begin
            case (reg_idx)
                mfp_pkg::REG_DEGREE:    degree_next  = pwdata[mfp_pkg::DEGW-1:0];
                mfp_pkg::REG_TOLERANCE: tol_next     = pwdata[mfp_pkg::TOLW-1:0];
                mfp_pkg::REG_CAP:       cap_next     = pwdata[mfp_pkg::CAPW-1:0];
                mfp_pkg::REG_COEFF_0:   coeff_next[0] = pwdata[mfp_pkg::CW-1:0];
                mfp_pkg::REG_COEFF_1:   coeff_next[1] = pwdata[mfp_pkg::CW-1:0];
                mfp_pkg::REG_COEFF_2:   coeff_next[2] = pwdata[mfp_pkg::CW-1:0];
                mfp_pkg::REG_COEFF_3:   coeff_next[3] = pwdata[mfp_pkg::CW-1:0];
                mfp_pkg::REG_COEFF_4:   coeff_next[4] = pwdata[mfp_pkg::CW-1:0];
                default:                degree_next  = degree_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            mfp_pkg::REG_DEGREE:    prdata = mfp_pkg::DATA_W'(degree_reg);
            mfp_pkg::REG_TOLERANCE: prdata = mfp_pkg::DATA_W'(tol_reg);
            mfp_pkg::REG_CAP:       prdata = mfp_pkg::DATA_W'(cap_reg);
            mfp_pkg::REG_COEFF_0:   prdata = mfp_pkg::DATA_W'(signed'(coeff_reg[0]));
            mfp_pkg::REG_COEFF_1:   prdata = mfp_pkg::DATA_W'(signed'(coeff_reg[1]));
            mfp_pkg::REG_COEFF_2:   prdata = mfp_pkg::DATA_W'(signed'(coeff_reg[2]));
            mfp_pkg::REG_COEFF_3:   prdata = mfp_pkg::DATA_W'(signed'(coeff_reg[3]));
            mfp_pkg::REG_COEFF_4:   prdata = mfp_pkg::DATA_W'(signed'(coeff_reg[4]));
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg <= mfp_pkg::DEGW'(1);
            tol_reg    <= mfp_pkg::TOLW'(66);
            cap_reg    <= mfp_pkg::CAPW'(64);
            coeff_reg  <= {mfp_pkg::CW'(0), mfp_pkg::CW'(0), mfp_pkg::CW'(0),
                           mfp_pkg::CW'(1), mfp_pkg::CW'(0)};
        end else begin
            degree_reg <= degree_next;
            tol_reg    <= tol_next;
            cap_reg    <= cap_next;
            coeff_reg  <= coeff_next;
        end
    end

    mfp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    mfp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_item   (s_data),
        .out_item  (m_data),
        .degree    (degree_reg),
        .tolerance (tol_reg),
        .cap       (cap_reg),
        .coeffs    (coeff_reg)
    );

    a_load_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load && cmd.out_load))
        else $error("load and result hand-off in the same cycle");

    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("result loaded without valid");

    a_unit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sts.ev_done && sts.sec_done))
        else $error("evaluator and secant finished together");

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction accepted during a search");

endmodule

FILE: tb/sv/modified_false_position_root_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modified_false_position_root_test
// Drives intervals into the root finder under several register settings and
// idle patterns, predicts each search in fixed point, and checks every result.
// ----------------------------------------------------------------------------
module modified_false_position_root_test;

    localparam logic signed [63:0] V48_HI = 64'sd140737488355327;
    localparam logic signed [63:0] V48_LO = -64'sd140737488355328;

    class root_scoreboard;
        mfp_pkg::out_item_t pending[$];
        int        errors;
        logic [2:0]         degree;
        logic [30:0]        tolerance;
        logic [7:0]         cap;
        logic signed [63:0] coeff[5];

        function new();
            errors = 0;
            degree = 3'd1;
            tolerance = 31'd66;
            cap = 8'd64;
            coeff[0] = 0; coeff[1] = 1; coeff[2] = 0; coeff[3] = 0; coeff[4] = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                mfp_pkg::REG_DEGREE: begin
                    degree = val[2:0];
                end
                mfp_pkg::REG_TOLERANCE: begin
                    tolerance = val[30:0];
                end
                mfp_pkg::REG_CAP: begin
                    cap = val[7:0];
                end
                default: begin
                    coeff[idx - mfp_pkg::REG_COEFF_0] = 64'(signed'(val[15:0]));
                end
            endcase
        endfunction

        function logic [63:0] mag(logic signed [63:0] v);
            return v < 0 ? -v : v;
        endfunction

        function int sgn(logic signed [63:0] v);
            return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
        endfunction

        function logic signed [63:0] scaled_product(logic signed [63:0] acc,
                                                    logic signed [31:0] x);
            logic [63:0] ma, mb, hp, lp, q, lim;
            logic        neg;
            neg = (acc < 0) != (x < 0);
            ma = mag(acc);
            mb = mag(64'(x));
            hp = (ma >> 24) * mb;
            lp = (ma & 64'hFFFFFF) * mb;
            lim = 64'd1 << 48;
            if (hp > (lim >> 8)) q = lim;
            else q = (hp << 8) + (lp >> 16);
            if (q > lim) q = lim;
            return neg ? -$signed(q) : $signed(q);
        endfunction

        function logic signed [63:0] horner(logic signed [31:0] x);
            int                 d;
            logic signed [63:0] acc;
            d = (degree > 4) ? 4 : degree;
            acc = coeff[d] <<< 16;
            for (int i = d - 1; i >= 0; i--) begin
                acc = scaled_product(acc, x) + (coeff[i] <<< 16);
                if (acc > V48_HI) acc = V48_HI;
                if (acc < V48_LO) acc = V48_LO;
            end
            return acc;
        endfunction

        function logic signed [31:0] chord(logic signed [31:0] a, logic signed [31:0] b,
                                           logic signed [63:0] fa, logic signed [63:0] fb);
            logic signed [63:0] w;
            logic [63:0]        n, s, q;
            w = 64'(b) - 64'(a);
            n = mag(fa);
            s = mag(fa) + mag(fb);
            if (s == 0) return a;
            while (s >= (64'd1 << 31)) begin
                n >>= 1;
                s >>= 1;
            end
            q = mag(w) * n / s;
            return (w < 0) ? 32'(64'(a) - $signed(q)) : 32'(64'(a) + $signed(q));
        endfunction

        function void note_interval(mfp_pkg::in_item_t it);
            mfp_pkg::out_item_t r;
            logic signed [31:0] lo, hi, prv, cur, nxt;
            logic signed [63:0] flo, fhi, fcur, fprv, flo_use, fhi_use;
            logic [7:0]         k;
            logic               same;
            lo = it.left_end;
            hi = it.right_end;
            flo = horner(lo);
            fhi = horner(hi);
            k = 0;
            cur = 0;
            if (sgn(flo) * sgn(fhi) > 0) begin
                r.outcome = mfp_pkg::OUT_NO_SIGN;
            end else begin
                prv = lo;
                cur = chord(lo, hi, flo, fhi);
                forever begin
                    if (k >= cap) begin
                        r.outcome = mfp_pkg::OUT_CAP;
                        break;
                    end
                    fcur = horner(cur);
                    fprv = horner(prv);
                    if (mag(fcur) <= 64'(tolerance)) begin
                        r.outcome = mfp_pkg::OUT_CONVERGED;
                        break;
                    end
                    if (prv != 0 && mag(fprv - fcur) <=
                            ((64'(tolerance) * mag(64'(prv))) >> 16)) begin
                        r.outcome = mfp_pkg::OUT_CONVERGED;
                        break;
                    end
                    same = sgn(fprv) * sgn(fcur) > 0;
                    if (sgn(flo) * sgn(fcur) < 0) begin
                        flo_use = same ? flo / 2 : flo;
                        nxt = chord(lo, cur, flo_use, fcur);
                        hi = cur;
                        fhi = fcur;
                    end else if (sgn(fcur) * sgn(fhi) < 0) begin
                        fhi_use = same ? fhi / 2 : fhi;
                        nxt = chord(cur, hi, fcur, fhi_use);
                        lo = cur;
                        flo = fcur;
                    end else begin
                        r.outcome = mfp_pkg::OUT_STALLED;
                        break;
                    end
                    prv = cur;
                    cur = nxt;
                    k++;
                end
            end
            r.root_value = cur;
            r.iterations_used = k;
            pending.push_back(r);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_root(mfp_pkg::out_item_t got);
            mfp_pkg::out_item_t want;
            if (pending.size() == 0) begin
                report("result with nothing outstanding");
                return;
            end
            want = pending.pop_front();
            if (got.root_value !== want.root_value)
                report($sformatf("root_value %h, want %h", got.root_value, want.root_value));
            if (got.iterations_used !== want.iterations_used)
                report($sformatf("iterations_used %0d, want %0d",
                                 got.iterations_used, want.iterations_used));
            if (got.outcome !== want.outcome)
                report($sformatf("outcome %0d, want %0d", got.outcome, want.outcome));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    mfp_pkg::in_item_t  s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    mfp_pkg::out_item_t m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [mfp_pkg::ADDR_W-1:0] paddr = '0;
    logic [mfp_pkg::DATA_W-1:0] pwdata = '0;
    logic [mfp_pkg::DATA_W-1:0] prdata;
    logic        pready;

    root_scoreboard roots = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_off = 0;

    always #10 aclk = ~aclk;

    modified_false_position_root dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) roots.check_root(m_data);
    end

    always @(negedge aclk) begin
        if (hold_off > 0) begin
            m_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task write_reg(logic [2:0] idx, logic [31:0] val);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        roots.set_reg(idx, val);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task send_interval(logic signed [31:0] a, logic signed [31:0] b);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_valid = 1'b1;
        s_data = '{left_end: a, right_end: b};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        roots.note_interval(s_data);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task drain();
        while (roots.pending.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task setup(logic [2:0] deg, logic [30:0] tol, logic [7:0] lim,
               int c0, int c1, int c2, int c3, int c4);
        write_reg(mfp_pkg::REG_DEGREE, 32'(deg));
        write_reg(mfp_pkg::REG_TOLERANCE, 32'(tol));
        write_reg(mfp_pkg::REG_CAP, 32'(lim));
        write_reg(mfp_pkg::REG_COEFF_0, 32'(c0));
        write_reg(mfp_pkg::REG_COEFF_1, 32'(c1));
        write_reg(mfp_pkg::REG_COEFF_2, 32'(c2));
        write_reg(mfp_pkg::REG_COEFF_3, 32'(c3));
        write_reg(mfp_pkg::REG_COEFF_4, 32'(c4));
    endtask

    function automatic logic signed [31:0] pick_x();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return 32'($signed($urandom_range(8)) - 4) <<< 16;
        endcase
    endfunction

    task random_phase(int n);
        logic signed [31:0] a, b;
        for (int i = 0; i < n; i++) begin
            a = pick_x();
            b = pick_x();
            if ($urandom_range(3) != 0 && a > b) send_interval(b, a);
            else send_interval(a, b);
        end
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: p(x) = x
        send_interval(-32'sd65536, 32'sd131072);
        send_interval(32'sd65536, 32'sd131072);
        send_interval(32'sd0, 32'sd0);
        send_interval(32'sh7FFFFFFF, 32'sh80000000);
        send_interval(32'sh80000000, 32'sh7FFFFFFF);
        drain();

        // x^2 - 2, cap 0 and cap 1, extremes of coefficients
        setup(3'd2, 31'd0, 8'd0, -2, 0, 1, 0, 0);
        send_interval(0, 3 << 16);
        drain();
        write_reg(mfp_pkg::REG_CAP, 32'd1);
        send_interval(0, 3 << 16);
        drain();
        write_reg(mfp_pkg::REG_CAP, 32'd255);
        send_interval(0, 3 << 16);
        send_interval(3 << 16, 0);
        send_interval(-32'sd196608, 32'sd196608);
        drain();
        setup(3'd7, 31'h7FFFFFFF, 8'd255, -32768, 32767, -32768, 32767, -32768);
        send_interval(32'sh80000000, 32'sh7FFFFFFF);
        send_interval(-32'sd65536, 32'sd65536);
        drain();
        setup(3'd0, 31'd66, 8'd64, 0, 0, 0, 0, 0);
        send_interval(5, 9);
        drain();
        write_reg(mfp_pkg::REG_COEFF_0, 32'd3);
        send_interval(5, 9);
        drain();
        setup(3'd4, 31'd1, 8'd255, 32767, 0, -32768, 0, 1);
        send_interval(0, 32'sd655360);
        send_interval(32'sh80000000, 0);
        drain();

        // cubic x^3 - x - 2
        setup(3'd3, 31'd66, 8'd64, -2, -1, 0, 1, 0);
        random_phase(40);
        drain();

        send_idle_pct = 76;
        setup(3'd1, 31'd0, 8'd255, 7, -3, 0, 0, 0);
        random_phase(30);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 76;
        setup(3'd2, 31'd1000, 8'd20, -5, 1, 3, 0, 0);
        random_phase(30);
        drain();

        send_idle_pct = 25;
        recv_stall_pct = 25;
        setup(3'd4, 31'($urandom), 8'($urandom_range(1, 255)),
              $signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
              $signed(16'($urandom)), $signed(16'($urandom)));
        random_phase(30);
        drain();

        // receiver holds off while intervals keep arriving
        send_idle_pct = 0;
        recv_stall_pct = 0;
        setup(3'd3, 31'd66, 8'd64, 1, -4, 0, 1, 0);
        hold_off = 20000;
        random_phase(8);
        drain();
        random_phase(20);
        drain();

        if (roots.errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #400ms;
        $display("FAILURE");
        $finish;
    end
endmodule
